@@ hw/rtl/bblru_pkg.sv @@
// ----------------------------------------------------------------------------
// bblru_pkg: shared types and constants for the byte-budget lru cache
// Request codes, beat structs, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package bblru_pkg;

   localparam int DefMaxEntries = 16;
   localparam int DefKeyBits    = 64;
   localparam int DefTagBits    = 32;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] key;
      logic [31:0] frame_tag;
      logic [31:0] frame_bytes;
   } req_type_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_tag;
      logic        stored;
      logic [4:0]  evicted_count;
      logic [31:0] retained_bytes;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EVICT_RD,
      ST_EVICT,
      ST_STORE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ hw/rtl/byte_budget_lru_cache_top.sv @@
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_top: size-weighted lru cache with a byte budget
// Sequencer around key/tag/size memories, valid and rank flip-flops.
// ----------------------------------------------------------------------------
// Use: one request beat on req_ (lookup, insert, clear) gives one response
// beat on rsp_. csr_wr_en/csr_wr_data set the byte budget; the user must
// set it only while idle, which the block does not enforce. Entry payloads
// sit in a synchronous memory read one slot per cycle. A lookup or insert
// scans every slot, comparing each valid slot's key with the request key.
// An insert that fits the budget then reads and drops each evicted entry
// in ST_EVICT_RD and ST_EVICT, and stores the new entry in ST_STORE.
// Clear and unused codes go straight to the response. One request is
// worked at a time; req_ready is low until the response beat has been taken.
// Reset empties the cache and clears the budget; memory contents are left
// alone since a slot's data is only used while it is valid, so no clearing
// pass runs. When the receiver stalls, the response is held on rsp_ and no
// new request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_budget_lru_cache_top #(
   parameter int MAX_ENTRIES = bblru_pkg::DefMaxEntries,
   parameter int KEY_BITS    = bblru_pkg::DefKeyBits,
   parameter int TAG_BITS    = bblru_pkg::DefTagBits
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bblru_pkg::req_type_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bblru_pkg::rsp_type          rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [31:0]            csr_wr_data
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);
   localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

   // memory: key, tag, size per slot
   localparam int MW = KEY_BITS + TAG_BITS + 32;
   logic [MW-1:0] mem [MAX_ENTRIES];
   logic [MW-1:0] rd_q;
   logic          mem_we;
   logic [IW-1:0] mem_wa, mem_ra;
   logic [MW-1:0] mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q <= mem[mem_ra];
   end

   logic [KEY_BITS-1:0] rd_key;
   logic [TAG_BITS-1:0] rd_tag;
   logic [31:0]         rd_size;
   assign rd_key  = rd_q[MW-1 -: KEY_BITS];
   assign rd_tag  = rd_q[32 +: TAG_BITS];
   assign rd_size = rd_q[31:0];

   // control state
   bblru_pkg::state_type state_ff, state_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0] rank_ff [MAX_ENTRIES];
   logic [IW-1:0] rank_in [MAX_ENTRIES];
   logic [31:0]   cap_ff, bytes_ff, bytes_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   bblru_pkg::req_type_type req_ff, req_in;
   bblru_pkg::rsp_type rsp_ff, rsp_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          rvld_ff, rvld_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] hslot_ff, hslot_in;
   logic [TAG_BITS-1:0] htag_ff, htag_in;
   logic [4:0]    ev_ff, ev_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bblru_pkg::ST_IDLE;
         valid_ff <= '0;
         cap_ff   <= '0;
         bytes_ff <= '0;
         cnt_ff   <= '0;
         rvld_ff  <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         bytes_ff <= bytes_in;
         cnt_ff   <= cnt_in;
         rvld_ff  <= rvld_in;
         for (int i = 0; i < MAX_ENTRIES; i++) rank_ff[i] <= rank_in[i];
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      ridx_ff  <= ridx_in;
      hit_ff   <= hit_in;
      hslot_ff <= hslot_in;
      htag_ff  <= htag_in;
      ev_ff    <= ev_in;
   end

   // least recent slot: rank equals count - 1
   logic [IW-1:0] lru_slot;
   logic [CW-1:0] cnt_m1;
   assign cnt_m1 = cnt_ff - CW'(1);
   always_comb begin
      lru_slot = '0;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (valid_ff[i] && CW'(rank_ff[i]) == cnt_m1) lru_slot = IW'(i);
   end

   // lowest free slot
   logic [IW-1:0] free_slot;
   always_comb begin
      free_slot = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--)
         if (!valid_ff[i]) free_slot = IW'(i);
   end

   logic [KEY_BITS-1:0] req_key;
   assign req_key = KEY_BITS'(req_ff.key);
   logic ins_ok;
   assign ins_ok = cap_ff != 0 && req_ff.frame_bytes != 0 && req_ff.frame_bytes <= cap_ff;
   logic [32:0] need;
   assign need = {1'b0, bytes_ff} + {1'b0, req_ff.frame_bytes};

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_in[i] = rank_ff[i];
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      idx_in   = idx_ff;
      rvld_in  = 1'b0;
      ridx_in  = idx_ff;
      hit_in   = hit_ff;
      hslot_in = hslot_ff;
      htag_in  = htag_ff;
      ev_in    = ev_ff;
      mem_we   = 1'b0;
      mem_wa   = free_slot;
      mem_wd   = {req_key, TAG_BITS'(req_ff.frame_tag), req_ff.frame_bytes};
      mem_ra   = idx_ff;
      req_ready = 1'b0;

      // registered compare of the slot read last cycle
      if (rvld_ff && valid_ff[ridx_ff] && rd_key == req_key) begin
         hit_in   = 1'b1;
         hslot_in = ridx_ff;
         htag_in  = rd_tag;
      end

      case (state_ff)
         bblru_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               idx_in = '0;
               hit_in = 1'b0;
               ev_in  = '0;
               if (req_data.req_type == bblru_pkg::REQ_LOOKUP ||
                   (req_data.req_type == bblru_pkg::REQ_INSERT)) begin
                  state_in = bblru_pkg::ST_SCAN;
               end else begin
                  if (req_data.req_type == bblru_pkg::REQ_CLEAR) begin
                     valid_in = '0;
                     for (int i = 0; i < MAX_ENTRIES; i++) rank_in[i] = '0;
                     bytes_in = '0;
                     cnt_in   = '0;
                  end
                  state_in = bblru_pkg::ST_DONE;
               end
            end
         end
         bblru_pkg::ST_SCAN: begin
            // one slot read per cycle; its compare runs in the next cycle
            mem_ra  = idx_ff;
            rvld_in = !(idx_ff == LAST && rvld_ff && ridx_ff == LAST);
            if (idx_ff != LAST) idx_in = idx_ff + IW'(1);
            if (rvld_ff && ridx_ff == LAST) begin
               rvld_in = 1'b0;
               if (req_ff.req_type == bblru_pkg::REQ_LOOKUP) begin
                  if (hit_in) begin
                     for (int i = 0; i < MAX_ENTRIES; i++)
                        if (valid_ff[i] && rank_ff[i] < rank_ff[hslot_in])
                           rank_in[i] = rank_ff[i] + IW'(1);
                     rank_in[hslot_in] = '0;
                  end
                  state_in = bblru_pkg::ST_DONE;
               end else if (!ins_ok) begin
                  state_in = bblru_pkg::ST_DONE;
               end else if (hit_in) begin
                  idx_in   = hslot_in;
                  state_in = bblru_pkg::ST_EVICT_RD;
               end else begin
                  hit_in   = 1'b0;
                  state_in = bblru_pkg::ST_EVICT_RD;
                  if (cnt_ff != 0 && (need > {1'b0, cap_ff} || cnt_ff == FULL))
                     idx_in = lru_slot;
                  else
                     state_in = bblru_pkg::ST_STORE;
               end
            end
         end
         bblru_pkg::ST_EVICT_RD: begin
            // fetch size of the slot being dropped
            mem_ra   = idx_ff;
            state_in = bblru_pkg::ST_EVICT;
         end
         bblru_pkg::ST_EVICT: begin
            for (int i = 0; i < MAX_ENTRIES; i++)
               if (valid_ff[i] && rank_ff[i] > rank_ff[idx_ff])
                  rank_in[i] = rank_ff[i] - IW'(1);
            rank_in[idx_ff] = '0;
            valid_in[idx_ff] = 1'b0;
            bytes_in = bytes_ff - rd_size;
            cnt_in   = cnt_m1;
            ev_in    = ev_ff + 5'd1;
            hit_in   = 1'b0;
            state_in = bblru_pkg::ST_STORE;
            // check again against the updated totals next pass
            if (cnt_in != 0) begin
               if ({1'b0, bytes_in} + {1'b0, req_ff.frame_bytes} > {1'b0, cap_ff}) begin
                  state_in = bblru_pkg::ST_EVICT_RD;
               end
            end
            idx_in = idx_ff;
            if (state_in == bblru_pkg::ST_EVICT_RD) begin
               // new least recent: old rank count - 1, or count - 2 when the
               // dropped slot was itself the least recent
               for (int i = 0; i < MAX_ENTRIES; i++)
                  if (valid_ff[i] && i != int'(idx_ff) &&
                      CW'(rank_ff[i]) == cnt_m1 -
                      ((rank_ff[i] > rank_ff[idx_ff]) ? CW'(0) : CW'(1)))
                     idx_in = IW'(i);
            end
         end
         bblru_pkg::ST_STORE: begin
            if (cnt_ff == FULL) begin
               idx_in   = lru_slot;
               state_in = bblru_pkg::ST_EVICT_RD;
            end else begin
               mem_we = 1'b1;
               for (int i = 0; i < MAX_ENTRIES; i++)
                  if (valid_ff[i]) rank_in[i] = rank_ff[i] + IW'(1);
               rank_in[free_slot]  = '0;
               valid_in[free_slot] = 1'b1;
               bytes_in = bytes_ff + req_ff.frame_bytes;
               cnt_in   = cnt_ff + CW'(1);
               state_in = bblru_pkg::ST_DONE;
            end
         end
         bblru_pkg::ST_DONE: begin
            // response built from final totals; held until taken
            state_in = bblru_pkg::ST_DONE;
         end
         default: state_in = bblru_pkg::ST_IDLE;
      endcase

      if (state_ff == bblru_pkg::ST_DONE && rsp_ready) state_in = bblru_pkg::ST_IDLE;
      if (state_in == bblru_pkg::ST_DONE && state_ff != bblru_pkg::ST_DONE) begin
         rsp_in.hit = req_ff.req_type == bblru_pkg::REQ_LOOKUP && hit_in;
         rsp_in.found_tag = rsp_in.hit ? 32'(htag_in) : 32'd0;
         rsp_in.stored = state_ff == bblru_pkg::ST_STORE;
         rsp_in.evicted_count = req_ff.req_type == bblru_pkg::REQ_INSERT ? ev_in : 5'd0;
         rsp_in.retained_bytes = bytes_in;
         rsp_in.entry_count = 5'(cnt_in);
         if (state_ff == bblru_pkg::ST_IDLE) begin
            rsp_in.hit = 1'b0;
            rsp_in.found_tag = '0;
            rsp_in.stored = 1'b0;
            rsp_in.evicted_count = '0;
         end
      end
   end

   assign rsp_valid = state_ff == bblru_pkg::ST_DONE;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
